/* rtl/core/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the four-sensor temperature controller.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Raw conversion width and the reduced temperature width.
  localparam int SENSOR_BITS  = 10;
  localparam int TEMP_BITS    = 8;
  localparam int NUM_SENSORS  = 4;
  localparam int DROP_BITS    = SENSOR_BITS - TEMP_BITS;

  // Result field widths.
  localparam int SUM_BITS     = 10;
  localparam int SQ_BITS      = 2 * TEMP_BITS;
  localparam int SUMSQ_BITS   = SQ_BITS + 2;
  localparam int WIDE_BITS    = 2 * SUM_BITS;
  localparam int VAR_BITS     = 18;
  localparam int LEVEL_BITS   = 15;
  localparam int LEVEL16_BITS = LEVEL_BITS + 4;
  localparam int DUTY_BITS    = 8;
  localparam int GAIN_BITS    = 4;
  localparam int PROD_BITS    = TEMP_BITS + GAIN_BITS;

  localparam logic [GAIN_BITS-1:0] DUTY_GAIN = GAIN_BITS'(10);
  localparam logic [PROD_BITS-1:0] DUTY_MAX  = PROD_BITS'(255);

  // Configuration register indexes (byte address bits [3:2]).
  localparam int CFG_ADDR_BITS = 4;
  localparam logic [1:0] REG_TARGET  = 2'd0;
  localparam logic [1:0] REG_FAN_OFF = 2'd1;
  localparam logic [1:0] REG_FAN_ON  = 2'd2;

  typedef logic [NUM_SENSORS-1:0][SENSOR_BITS-1:0] samples_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [VAR_BITS-1:0] var16;
  } stats_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0]  target;
    logic [LEVEL_BITS-1:0] fan_off;
    logic [LEVEL_BITS-1:0] fan_on;
  } cfg_t;

endpackage

/* rtl/core/tsc_stats.sv */
// ----------------------------------------------------------------------------
// tsc_stats
// Reduces the four samples to 8 bits and forms their sum and 16x variance.
// ----------------------------------------------------------------------------
module tsc_stats (
  input  tsc_pkg::samples_t smp,
  output tsc_pkg::stats_t   stats
);

  logic [tsc_pkg::TEMP_BITS-1:0]  temp  [tsc_pkg::NUM_SENSORS];
  logic [tsc_pkg::SQ_BITS-1:0]    sq    [tsc_pkg::NUM_SENSORS];
  logic [tsc_pkg::SUM_BITS-1:0]   sum;
  logic [tsc_pkg::SUMSQ_BITS-1:0] sumsq;
  logic [tsc_pkg::WIDE_BITS-1:0]  sum_sq;
  logic [tsc_pkg::WIDE_BITS-1:0]  var_wide;

  always_comb begin
    sum   = '0;
    sumsq = '0;
    for (int k = 0; k < tsc_pkg::NUM_SENSORS; k++) begin
      temp[k] = smp[k][tsc_pkg::SENSOR_BITS-1:tsc_pkg::DROP_BITS];
      sq[k]   = tsc_pkg::SQ_BITS'(temp[k]) * tsc_pkg::SQ_BITS'(temp[k]);
      sum     = sum + tsc_pkg::SUM_BITS'(temp[k]);
      sumsq   = sumsq + tsc_pkg::SUMSQ_BITS'(sq[k]);
    end
    sum_sq = tsc_pkg::WIDE_BITS'(sum) * tsc_pkg::WIDE_BITS'(sum);
    // Four times the sum of squares never falls below the squared sum.
    var_wide = {sumsq, 2'b00} - sum_sq;
    stats.sum   = sum;
    stats.var16 = var_wide[tsc_pkg::VAR_BITS-1:0];
  end

endmodule

/* rtl/core/tsc_ctrl.sv */
// ----------------------------------------------------------------------------
// tsc_ctrl
// Fan hysteresis, heater compare and heater duty, with the two state flags.
// ----------------------------------------------------------------------------
module tsc_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           upd,
  input  tsc_pkg::stats_t                stats,
  input  tsc_pkg::cfg_t                  cfg,
  output logic                           fan_nxt,
  output logic                           heater_nxt,
  output logic [tsc_pkg::DUTY_BITS-1:0]  duty
);

  logic                               fan_state_r;
  logic                               heater_state_r;
  logic [tsc_pkg::LEVEL16_BITS-1:0]   var_ext;
  logic [tsc_pkg::LEVEL16_BITS-1:0]   on16;
  logic [tsc_pkg::LEVEL16_BITS-1:0]   off16;
  logic [tsc_pkg::TEMP_BITS-1:0]      mean;
  logic [tsc_pkg::TEMP_BITS-1:0]      diff;
  logic [tsc_pkg::PROD_BITS-1:0]      prod;

  always_comb begin
    var_ext = tsc_pkg::LEVEL16_BITS'(stats.var16);
    on16    = {cfg.fan_on, 4'b0000};
    off16   = {cfg.fan_off, 4'b0000};
    // The on test wins when the two levels overlap.
    if (var_ext > on16) begin
      fan_nxt = 1'b1;
    end else if (var_ext < off16) begin
      fan_nxt = 1'b0;
    end else begin
      fan_nxt = fan_state_r;
    end

    mean = stats.sum[tsc_pkg::SUM_BITS-1:2];
    if (mean > cfg.target) begin
      heater_nxt = 1'b0;
    end else if (mean < cfg.target) begin
      heater_nxt = 1'b1;
    end else begin
      heater_nxt = heater_state_r;
    end

    // Only used when the mean is below the target, so it never wraps there.
    diff = cfg.target - mean;
    prod = tsc_pkg::PROD_BITS'(diff) *
           tsc_pkg::PROD_BITS'(tsc_pkg::DUTY_GAIN);
    if (mean >= cfg.target) begin
      duty = '0;
    end else if (prod > tsc_pkg::DUTY_MAX) begin
      duty = tsc_pkg::DUTY_MAX[tsc_pkg::DUTY_BITS-1:0];
    end else begin
      duty = prod[tsc_pkg::DUTY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_state_r    <= 1'b0;
      heater_state_r <= 1'b0;
    end else if (upd) begin
      fan_state_r    <= fan_nxt;
      heater_state_r <= heater_nxt;
    end
  end

  a_fan_on: assert property (@(posedge clk) disable iff (!rst_n)
    upd && (var_ext > on16) |=> fan_state_r)
    else $error("fan did not turn on above the on level");

  a_heater_on: assert property (@(posedge clk) disable iff (!rst_n)
    upd && (mean < cfg.target) |=> heater_state_r)
    else $error("heater did not turn on below target");

  a_heater_off: assert property (@(posedge clk) disable iff (!rst_n)
    upd && (mean > cfg.target) |=> !heater_state_r)
    else $error("heater did not turn off above target");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(fan_state_r) && $stable(heater_state_r))
    else $error("state flags changed without a transaction");

endmodule

/* rtl/core/four_sensor_temperature_controller.sv */
// ----------------------------------------------------------------------------
// four_sensor_temperature_controller
// Mean, variance, fan hysteresis and heater drive for four sensor samples.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction on the in_ channel carries four raw 10-bit conversions.
//   Each produces exactly one transaction on the out_ channel with the sum
//   of the reduced samples, the variance times 16, the fan and heater flags
//   and the heater duty value.
//   Samples are captured in an input register; the result is computed from
//   it and captured in the output register, which drives the out_ channel.
//   While out_tready is high, one transaction per cycle is sustained,
//   since each register loads in the same cycle that its content moves on.
//   If the receiver holds out_tready low, the result stays in the output
//   register and one more transaction waits in the input register before
//   in_tready drops.
//   The fan and heater flags update in the order the results are produced.
//   Reset clears both flags, all three configuration registers and the
//   pipeline. Write the configuration registers through the cfg_ port only
//   while no transaction is in flight.
// ----------------------------------------------------------------------------
module four_sensor_temperature_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample_a[9:0], sample_b[19:10], sample_c[29:20], sample_d[39:30]
  input  logic [39:0]                       in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mean_quarters[9:0], variance_sixteenths[27:10], fan_enable[28],
  // heater_enable[29], heater_duty[37:30], zero[39:38]
  output logic [39:0]                       out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tsc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  tsc_pkg::samples_t                 smp_r;
  logic                              smp_valid_r;
  logic                              out_valid_r;
  tsc_pkg::stats_t                   res_stats_r;
  logic                              res_fan_r;
  logic                              res_heater_r;
  logic [tsc_pkg::DUTY_BITS-1:0]     res_duty_r;
  tsc_pkg::cfg_t                     cfg_r;
  tsc_pkg::stats_t                   stats;
  logic                              fan_nxt;
  logic                              heater_nxt;
  logic [tsc_pkg::DUTY_BITS-1:0]     duty;
  logic                              out_load;
  logic                              in_accept;
  logic                              cfg_write;
  logic [1:0]                        cfg_idx;

  assign out_load  = smp_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !smp_valid_r || out_load;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        smp_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      smp_r <= in_tdata;
    end
    if (out_load) begin
      res_stats_r  <= stats;
      res_fan_r    <= fan_nxt;
      res_heater_r <= heater_nxt;
      res_duty_r   <= duty;
    end
  end

  tsc_stats u_stats (
    .smp   (smp_r),
    .stats (stats)
  );

  tsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (out_load),
    .stats      (stats),
    .cfg        (cfg_r),
    .fan_nxt    (fan_nxt),
    .heater_nxt (heater_nxt),
    .duty       (duty)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_duty_r, res_heater_r, res_fan_r,
                       res_stats_r.var16, res_stats_r.sum};

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        tsc_pkg::REG_TARGET: begin
          cfg_r.target <= cfg_pwdata[tsc_pkg::TEMP_BITS-1:0];
        end
        tsc_pkg::REG_FAN_OFF: begin
          cfg_r.fan_off <= cfg_pwdata[tsc_pkg::LEVEL_BITS-1:0];
        end
        tsc_pkg::REG_FAN_ON: begin
          cfg_r.fan_on <= cfg_pwdata[tsc_pkg::LEVEL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tsc_pkg::REG_TARGET:  cfg_prdata = 32'(cfg_r.target);
      tsc_pkg::REG_FAN_OFF: cfg_prdata = 32'(cfg_r.fan_off);
      tsc_pkg::REG_FAN_ON:  cfg_prdata = 32'(cfg_r.fan_on);
      default:              cfg_prdata = '0;
    endcase
  end

endmodule
